FILE: design/damped_spring_force_assert.svh
// Assertion macros for the damped spring force block.
// Used by the top level; expects clk and rst in scope.
`ifndef DAMPED_SPRING_FORCE_ASSERT_SVH
`define DAMPED_SPRING_FORCE_ASSERT_SVH
`ifndef SYNTH
`define DSF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("damped_spring_force: assertion failed");
`define DSF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("damped_spring_force: assertion failed");
`else
`define DSF_ASSERT_IMP(lbl, ante, cons)
`define DSF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: design/dsf_pkg.sv
// Shared widths, constants and payload structs of the damped spring force block.
// No dependencies.
package dsf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int COEF_W    = 31;
  localparam int DIFF_W    = POS_W + 1;
  localparam int MAG_W     = POS_W;
  localparam int HALF_W    = MAG_W - 1;
  localparam int SQ_W      = 2 * HALF_W + 1;
  localparam int ROOT_W    = MAG_W;
  localparam int LEN_W     = ROOT_W + 1;
  localparam int QUO_W     = FRAC_BITS + 2;
  localparam int NUM_W     = MAG_W + FRAC_BITS;
  localparam int CMP_W     = LEN_W + QUO_W;
  localparam int SQRT_W    = 2 * ROOT_W;
  localparam int SQRT_STEPS = ROOT_W;

  // product and term widths (magnitudes, signed terms carry one more bit)
  localparam int HMAG_W  = LEN_W;
  localparam int HSPLIT  = 17;
  localparam int HPROD_W = HMAG_W + COEF_W;
  localparam int HOOKE_W = HPROD_W - FRAC_BITS + 1;
  localparam int PPROD_W = MAG_W + QUO_W;
  localparam int PMAG_W  = PPROD_W - FRAC_BITS;
  localparam int PROJ_W  = PMAG_W + 2;
  localparam int PSPLIT  = 18;
  localparam int DPROD_W = PROJ_W - 1 + COEF_W;
  localparam int DTERM_W = DPROD_W - FRAC_BITS + 1;
  localparam int TOT_W   = DTERM_W + 1;
  localparam int TSPLIT  = 26;
  localparam int FPROD_W = TOT_W - 1 + QUO_W;
  localparam int FRC_W   = FPROD_W - FRAC_BITS + 1;

  localparam logic signed [POS_W-1:0] FORCE_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam logic signed [POS_W-1:0] FORCE_MIN = {1'b1, {(POS_W-1){1'b0}}};

  typedef struct packed {
    logic signed [POS_W-1:0] pos_a_x;
    logic signed [POS_W-1:0] pos_a_y;
    logic signed [POS_W-1:0] pos_b_x;
    logic signed [POS_W-1:0] pos_b_y;
    logic signed [POS_W-1:0] vel_a_x;
    logic signed [POS_W-1:0] vel_a_y;
    logic signed [POS_W-1:0] vel_b_x;
    logic signed [POS_W-1:0] vel_b_y;
    logic [COEF_W-1:0]       rest_length;
    logic [COEF_W-1:0]       stiffness;
    logic [COEF_W-1:0]       damping;
  } dsf_in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic                    degenerate;
    logic                    saturated;
  } dsf_out_t;

  // per-spring values that ride alongside the length and direction math
  typedef struct packed {
    logic                     dx_neg;
    logic                     dy_neg;
    logic                     s;
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic signed [DIFF_W-1:0] rvx;
    logic signed [DIFF_W-1:0] rvy;
    logic [COEF_W-1:0]        rest;
    logic [COEF_W-1:0]        stiff;
    logic [COEF_W-1:0]        damp;
  } dsf_side_t;

  typedef struct packed {
    dsf_side_t        side;
    logic [SQ_W-1:0]  sum;
  } dsf_sq_t;

  typedef struct packed {
    dsf_side_t         side;
    logic [ROOT_W-1:0] root;
  } dsf_rt_t;

  typedef struct packed {
    dsf_side_t        side;
    logic [LEN_W-1:0] len;
    logic [QUO_W-1:0] uxm;
    logic [QUO_W-1:0] uym;
  } dsf_dv_t;

endpackage

FILE: design/dsf_if.sv
// Valid/ready channel interfaces for spring items and force results.
// Depends on dsf_pkg.
interface dsf_in_if import dsf_pkg::*; ();
  logic    valid;
  logic    ready;
  dsf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

interface dsf_out_if import dsf_pkg::*; ();
  logic     valid;
  logic     ready;
  dsf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
  modport monitor (input valid, input data, input ready);
endinterface

FILE: design/damped_spring_force.sv
// Damped spring force, Q16.16. Pipeline stages: 6 front, 33 root, 19 divide, 13 force.
// One spring per cycle unless the output stalls; every stage has its own valid bit, fills bubbles.
// The 32-step square root pipeline sets the latency; the last force stage is the output register.
// Synchronous active-high reset clears all valid bits; payload registers are not reset.
// Depends on dsf_pkg, dsf_if, dsf_prep, dsf_sqrt, dsf_div, dsf_force.
`include "damped_spring_force_assert.svh"
module damped_spring_force import dsf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  dsf_in_if.sink     spring,
  dsf_out_if.source  result
);

  logic    sq_valid;
  logic    sq_ready;
  dsf_sq_t sq_data;
  logic    rt_valid;
  logic    rt_ready;
  dsf_rt_t rt_data;
  logic    dv_valid;
  logic    dv_ready;
  dsf_dv_t dv_data;

  dsf_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (spring.valid),
    .in_ready  (spring.ready),
    .in_data   (spring.data),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_data  (sq_data)
  );

  dsf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_data   (sq_data),
    .out_valid (rt_valid),
    .out_ready (rt_ready),
    .out_data  (rt_data)
  );

  dsf_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rt_valid),
    .in_ready  (rt_ready),
    .in_data   (rt_data),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_data  (dv_data)
  );

  dsf_force u_force (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_data   (dv_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
  );

  // the input side only blocks when the whole pipe is full behind a held result
  `DSF_ASSERT_IMP(a_block_on_stall, !spring.ready, result.valid && !result.ready)
  `DSF_ASSERT_IMP(a_degen_zero, result.valid && result.data.degenerate, result.data.force_x == '0 && result.data.force_y == '0 && !result.data.saturated)
  `DSF_ASSERT_IMP(a_sat_at_rail, result.valid && result.data.saturated, result.data.force_x == FORCE_MAX || result.data.force_x == FORCE_MIN || result.data.force_y == FORCE_MAX || result.data.force_y == FORCE_MIN)

endmodule

FILE: design/dsf_prep.sv
// Front pipeline: differences, magnitudes, prescale and sum of squares.
// Depends on dsf_pkg.
module dsf_prep import dsf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dsf_in_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output dsf_sq_t out_data
);

  localparam int N = 6;

  typedef struct packed {
    dsf_in_t                  raw;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [HALF_W-1:0]        sa;
    logic [HALF_W-1:0]        sb;
    logic [2*HALF_W-1:0]      sqa;
    logic [2*HALF_W-1:0]      sqb;
    logic [SQ_W-1:0]          sum;
    dsf_side_t                side;
  } pp_t;

  pp_t        st [N];
  pp_t        nx [N];
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_data  = '{side: st[N-1].side, sum: st[N-1].sum};

  always_comb begin
    nx[0]     = '0;
    nx[0].raw = in_data;

    nx[1]            = st[0];
    nx[1].dx         = DIFF_W'(st[0].raw.pos_b_x) - DIFF_W'(st[0].raw.pos_a_x);
    nx[1].dy         = DIFF_W'(st[0].raw.pos_b_y) - DIFF_W'(st[0].raw.pos_a_y);
    nx[1].side.rvx   = DIFF_W'(st[0].raw.vel_b_x) - DIFF_W'(st[0].raw.vel_a_x);
    nx[1].side.rvy   = DIFF_W'(st[0].raw.vel_b_y) - DIFF_W'(st[0].raw.vel_a_y);
    nx[1].side.rest  = st[0].raw.rest_length;
    nx[1].side.stiff = st[0].raw.stiffness;
    nx[1].side.damp  = st[0].raw.damping;

    nx[2]             = st[1];
    nx[2].side.dx_neg = st[1].dx[DIFF_W-1];
    nx[2].side.dy_neg = st[1].dy[DIFF_W-1];
    nx[2].side.ax     = MAG_W'(st[1].dx[DIFF_W-1] ? -st[1].dx : st[1].dx);
    nx[2].side.ay     = MAG_W'(st[1].dy[DIFF_W-1] ? -st[1].dy : st[1].dy);

    // halve both legs when either one reaches 2^31
    nx[3]        = st[2];
    nx[3].side.s = st[2].side.ax[MAG_W-1] | st[2].side.ay[MAG_W-1];
    nx[3].sa     = nx[3].side.s ? st[2].side.ax[MAG_W-1:1] : st[2].side.ax[HALF_W-1:0];
    nx[3].sb     = nx[3].side.s ? st[2].side.ay[MAG_W-1:1] : st[2].side.ay[HALF_W-1:0];

    nx[4]     = st[3];
    nx[4].sqa = st[3].sa * st[3].sa;
    nx[4].sqb = st[3].sb * st[3].sb;

    nx[5]     = st[4];
    nx[5].sum = SQ_W'(st[4].sqa) + SQ_W'(st[4].sqb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

endmodule

FILE: design/dsf_sqrt.sv
// Integer square root, one result bit per pipeline stage.
// Depends on dsf_pkg.
module dsf_sqrt import dsf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dsf_sq_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output dsf_rt_t out_data
);

  localparam int N = SQRT_STEPS + 1;

  typedef struct packed {
    dsf_side_t         side;
    logic [SQRT_W-1:0] rem;
    logic [SQRT_W-1:0] root;
  } sq_t;

  sq_t          st [N];
  sq_t          nx [N];
  logic [SQRT_W:0]   trial [1:SQRT_STEPS];
  logic [SQRT_W-1:0] bitv  [1:SQRT_STEPS];
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_data  = '{side: st[N-1].side, root: st[N-1].root[ROOT_W-1:0]};

  // classic digit-by-digit root; stage k tests the bit at 2*(SQRT_STEPS-k)
  always_comb begin
    nx[0].side = in_data.side;
    nx[0].rem  = SQRT_W'(in_data.sum);
    nx[0].root = '0;
    for (int k = 1; k <= SQRT_STEPS; k++) begin
      bitv[k]  = SQRT_W'(1) << (SQRT_W - 2 * k);
      trial[k] = {1'b0, st[k-1].root} + {1'b0, bitv[k]};
      nx[k]    = st[k-1];
      if ({1'b0, st[k-1].rem} >= trial[k]) begin
        nx[k].rem  = st[k-1].rem - trial[k][SQRT_W-1:0];
        nx[k].root = (st[k-1].root >> 1) + bitv[k];
      end else begin
        nx[k].root = st[k-1].root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

endmodule

FILE: design/dsf_div.sv
// Unit direction: two restoring dividers, one quotient bit per stage.
// Depends on dsf_pkg.
module dsf_div import dsf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  dsf_rt_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output dsf_dv_t out_data
);

  localparam int N = QUO_W + 1;

  typedef struct packed {
    dsf_side_t        side;
    logic [LEN_W-1:0] len;
    logic [NUM_W-1:0] remx;
    logic [NUM_W-1:0] remy;
    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
  } dv_t;

  dv_t          st [N];
  dv_t          nx [N];
  logic [CMP_W-1:0] dvs [1:QUO_W];
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_data  = '{side: st[N-1].side, len: st[N-1].len,
                       uxm: st[N-1].qx, uym: st[N-1].qy};

  always_comb begin
    nx[0].side = in_data.side;
    // undo the prescale of the root
    nx[0].len  = in_data.side.s ? {in_data.root, 1'b0} : {1'b0, in_data.root};
    nx[0].remx = {in_data.side.ax, {FRAC_BITS{1'b0}}};
    nx[0].remy = {in_data.side.ay, {FRAC_BITS{1'b0}}};
    nx[0].qx   = '0;
    nx[0].qy   = '0;
    for (int k = 1; k <= QUO_W; k++) begin
      dvs[k] = CMP_W'(st[k-1].len) << (QUO_W - k);
      nx[k]  = st[k-1];
      if (CMP_W'(st[k-1].remx) >= dvs[k]) begin
        nx[k].remx           = NUM_W'(CMP_W'(st[k-1].remx) - dvs[k]);
        nx[k].qx[QUO_W - k]  = 1'b1;
      end
      if (CMP_W'(st[k-1].remy) >= dvs[k]) begin
        nx[k].remy           = NUM_W'(CMP_W'(st[k-1].remy) - dvs[k]);
        nx[k].qy[QUO_W - k]  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

endmodule

FILE: design/dsf_force.sv
// Hooke and damper terms, force along the direction, clamp; last stage is the output register.
// Depends on dsf_pkg.
module dsf_force import dsf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dsf_dv_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output dsf_out_t out_data
);

  localparam int N    = 13;
  localparam int HH_W = HMAG_W - HSPLIT + COEF_W;
  localparam int HL_W = HSPLIT + COEF_W;
  localparam int DH_W = PROJ_W - 1 - PSPLIT + COEF_W;
  localparam int DL_W = PSPLIT + COEF_W;
  localparam int FH_W = TOT_W - 1 - TSPLIT + QUO_W;
  localparam int FL_W = TSPLIT + QUO_W;

  typedef struct packed {
    dsf_side_t                 side;
    logic [LEN_W-1:0]          len;
    logic [QUO_W-1:0]          uxm;
    logic [QUO_W-1:0]          uym;
    logic                      degen;
    logic [HMAG_W-1:0]         hmag;
    logic                      hneg;
    logic [MAG_W-1:0]          rvxm;
    logic [MAG_W-1:0]          rvym;
    logic                      rvxn;
    logic                      rvyn;
    logic [HH_W-1:0]           hph;
    logic [HL_W-1:0]           hpl;
    logic [PPROD_W-1:0]        mx;
    logic [PPROD_W-1:0]        my;
    logic signed [HOOKE_W-1:0] hooke;
    logic signed [PMAG_W:0]    px;
    logic signed [PMAG_W:0]    py;
    logic signed [PROJ_W-1:0]  proj;
    logic [PROJ_W-2:0]         projm;
    logic                      projn;
    logic [DH_W-1:0]           dph;
    logic [DL_W-1:0]           dpl;
    logic signed [DTERM_W-1:0] dterm;
    logic signed [TOT_W-1:0]   total;
    logic [TOT_W-2:0]          totm;
    logic                      totn;
    logic [FH_W-1:0]           fxh;
    logic [FL_W-1:0]           fxl;
    logic [FH_W-1:0]           fyh;
    logic [FL_W-1:0]           fyl;
    logic signed [FRC_W-1:0]   fx;
    logic signed [FRC_W-1:0]   fy;
    dsf_out_t                  res;
  } fr_t;

  fr_t          st [N];
  fr_t          nx [N];
  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];
  assign out_data  = st[N-1].res;

  // all products are formed on magnitudes and truncate toward zero
  always_comb begin
    logic [HPROD_W-1:0]  hsum;
    logic [HOOKE_W-2:0]  hm;
    logic [PMAG_W-1:0]   pxm;
    logic [PMAG_W-1:0]   pym;
    logic [DPROD_W-1:0]  dsum;
    logic [DTERM_W-2:0]  dm;
    logic [FPROD_W-1:0]  fxs;
    logic [FPROD_W-1:0]  fys;
    logic [FRC_W-2:0]    fxm;
    logic [FRC_W-2:0]    fym;
    logic                sat_x;
    logic                sat_y;

    nx[0]      = '0;
    nx[0].side = in_data.side;
    nx[0].len  = in_data.len;
    nx[0].uxm  = in_data.uxm;
    nx[0].uym  = in_data.uym;

    nx[1]       = st[0];
    nx[1].degen = (st[0].len == '0);
    if (LEN_W'(st[0].side.rest) > st[0].len) begin
      nx[1].hneg = 1'b1;
      nx[1].hmag = LEN_W'(st[0].side.rest) - st[0].len;
    end else begin
      nx[1].hneg = 1'b0;
      nx[1].hmag = st[0].len - LEN_W'(st[0].side.rest);
    end
    nx[1].rvxn = st[0].side.rvx[DIFF_W-1];
    nx[1].rvyn = st[0].side.rvy[DIFF_W-1];
    nx[1].rvxm = MAG_W'(st[0].side.rvx[DIFF_W-1] ? -st[0].side.rvx : st[0].side.rvx);
    nx[1].rvym = MAG_W'(st[0].side.rvy[DIFF_W-1] ? -st[0].side.rvy : st[0].side.rvy);

    nx[2]     = st[1];
    nx[2].hph = st[1].hmag[HMAG_W-1:HSPLIT] * st[1].side.stiff;
    nx[2].hpl = st[1].hmag[HSPLIT-1:0] * st[1].side.stiff;
    nx[2].mx  = st[1].rvxm * st[1].uxm;
    nx[2].my  = st[1].rvym * st[1].uym;

    nx[3]       = st[2];
    hsum        = {st[2].hph, {HSPLIT{1'b0}}} + HPROD_W'(st[2].hpl);
    hm          = hsum[FRAC_BITS +: HOOKE_W-1];
    nx[3].hooke = st[2].hneg ? -signed'({1'b0, hm}) : signed'({1'b0, hm});
    pxm         = st[2].mx[FRAC_BITS +: PMAG_W];
    pym         = st[2].my[FRAC_BITS +: PMAG_W];
    nx[3].px    = (st[2].rvxn ^ st[2].side.dx_neg) ? -signed'({1'b0, pxm})
                                                   : signed'({1'b0, pxm});
    nx[3].py    = (st[2].rvyn ^ st[2].side.dy_neg) ? -signed'({1'b0, pym})
                                                   : signed'({1'b0, pym});

    nx[4]      = st[3];
    nx[4].proj = PROJ_W'(st[3].px) + PROJ_W'(st[3].py);

    nx[5]       = st[4];
    nx[5].projn = st[4].proj[PROJ_W-1];
    nx[5].projm = (PROJ_W-1)'(st[4].proj[PROJ_W-1] ? -st[4].proj : st[4].proj);

    nx[6]     = st[5];
    nx[6].dph = st[5].projm[PROJ_W-2:PSPLIT] * st[5].side.damp;
    nx[6].dpl = st[5].projm[PSPLIT-1:0] * st[5].side.damp;

    nx[7]       = st[6];
    dsum        = {st[6].dph, {PSPLIT{1'b0}}} + DPROD_W'(st[6].dpl);
    dm          = dsum[FRAC_BITS +: DTERM_W-1];
    nx[7].dterm = st[6].projn ? -signed'({1'b0, dm}) : signed'({1'b0, dm});

    nx[8]       = st[7];
    nx[8].total = TOT_W'(st[7].hooke) + TOT_W'(st[7].dterm);

    nx[9]      = st[8];
    nx[9].totn = st[8].total[TOT_W-1];
    nx[9].totm = (TOT_W-1)'(st[8].total[TOT_W-1] ? -st[8].total : st[8].total);

    nx[10]     = st[9];
    nx[10].fxh = st[9].totm[TOT_W-2:TSPLIT] * st[9].uxm;
    nx[10].fxl = st[9].totm[TSPLIT-1:0] * st[9].uxm;
    nx[10].fyh = st[9].totm[TOT_W-2:TSPLIT] * st[9].uym;
    nx[10].fyl = st[9].totm[TSPLIT-1:0] * st[9].uym;

    nx[11]    = st[10];
    fxs       = {st[10].fxh, {TSPLIT{1'b0}}} + FPROD_W'(st[10].fxl);
    fys       = {st[10].fyh, {TSPLIT{1'b0}}} + FPROD_W'(st[10].fyl);
    fxm       = fxs[FRAC_BITS +: FRC_W-1];
    fym       = fys[FRAC_BITS +: FRC_W-1];
    nx[11].fx = (st[10].side.dx_neg ^ st[10].totn) ? -signed'({1'b0, fxm})
                                                   : signed'({1'b0, fxm});
    nx[11].fy = (st[10].side.dy_neg ^ st[10].totn) ? -signed'({1'b0, fym})
                                                   : signed'({1'b0, fym});

    nx[12] = st[11];
    sat_x  = 1'b0;
    sat_y  = 1'b0;
    if (st[11].fx > FRC_W'(FORCE_MAX)) begin
      nx[12].res.force_x = FORCE_MAX;
      sat_x = 1'b1;
    end else if (st[11].fx < FRC_W'(FORCE_MIN)) begin
      nx[12].res.force_x = FORCE_MIN;
      sat_x = 1'b1;
    end else begin
      nx[12].res.force_x = st[11].fx[POS_W-1:0];
    end
    if (st[11].fy > FRC_W'(FORCE_MAX)) begin
      nx[12].res.force_y = FORCE_MAX;
      sat_y = 1'b1;
    end else if (st[11].fy < FRC_W'(FORCE_MIN)) begin
      nx[12].res.force_y = FORCE_MIN;
      sat_y = 1'b1;
    end else begin
      nx[12].res.force_y = st[11].fy[POS_W-1:0];
    end
    nx[12].res.saturated  = sat_x | sat_y;
    nx[12].res.degenerate = st[11].degen;
    // coincident endpoints: zero direction, no force
    if (st[11].degen) begin
      nx[12].res.force_x   = '0;
      nx[12].res.force_y   = '0;
      nx[12].res.saturated = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < N; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < N; k++) begin
      if (en[k]) st[k] <= nx[k];
    end
  end

endmodule
